@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, also while reset is held.
`define ADAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Check a property on every rising edge outside reset.
`define ADAL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

@@ rtl/adal_pkg.sv @@
// Shared types and constants of the device address allocator.
`timescale 1ns / 1ps
`default_nettype none

package adal_pkg;

    localparam int OPCODE_W = 2;
    localparam int MODEL_W  = 4;
    localparam int ADDR_W   = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] CFG_MODELS_RESET = 16'h000F;

    localparam logic [OPCODE_W-1:0] OP_PEEK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MODEL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

    localparam int CMD_FIFO_DEPTH = 2;

    // Classified request as it travels from the front to the engine.
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                model_ok;
        logic [ADDR_W-1:0]   rel;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/adal_req_if.sv @@
// Request channel: opcode, model code and release address.
`timescale 1ns / 1ps
`default_nettype none

interface adal_req_if;
    logic                             valid;
    logic                             ready;
    logic [adal_pkg::OPCODE_W-1:0]    opcode;
    logic [adal_pkg::MODEL_W-1:0]     model_code;
    logic [adal_pkg::ADDR_W-1:0]      release_address;

    modport source (output valid, output opcode, output model_code,
                    output release_address, input ready);
    modport sink   (input valid, input opcode, input model_code,
                    input release_address, output ready);
endinterface

`default_nettype wire

@@ rtl/adal_rsp_if.sv @@
// Response channel: granted address and status.
`timescale 1ns / 1ps
`default_nettype none

interface adal_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [adal_pkg::ADDR_W-1:0]      granted_address;
    logic [adal_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink   (input valid, input granted_address, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/adal_cfg_if.sv @@
// Configuration write channel for the accepted-models mask.
`timescale 1ns / 1ps
`default_nettype none

interface adal_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [adal_pkg::CFG_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/adal_front.sv @@
// Front end: mask register, request decode and model check.
`timescale 1ns / 1ps
`default_nettype none

module adal_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    adal_cfg_if.sink      i_cfg,
    adal_req_if.sink      i_req,
    input  wire logic     i_clearing,
    output adal_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready
);

    logic [adal_pkg::CFG_W-1:0] r_models;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_models <= adal_pkg::CFG_MODELS_RESET;
        end else if (i_cfg.valid) begin
            r_models <= i_cfg.data;
        end
    end

    // Hold requests back while the status store is being swept.
    assign i_req.ready = i_cmd_ready && !i_clearing;
    assign o_cmd_valid = i_req.valid && !i_clearing;

    always_comb begin
        o_cmd.op       = i_req.opcode;
        o_cmd.model_ok = r_models[i_req.model_code];
        o_cmd.rel      = i_req.release_address;
    end

endmodule

`default_nettype wire

@@ rtl/adal_cmd_fifo.sv @@
// Short command queue between front end and engine.
`timescale 1ns / 1ps
`default_nettype none

module adal_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire adal_pkg::t_cmd i_cmd,
    input  wire logic           i_valid,
    output logic                o_ready,
    output adal_pkg::t_cmd      o_cmd,
    output logic                o_valid,
    input  wire logic           i_ready
);

    localparam int Depth = adal_pkg::CMD_FIFO_DEPTH;
    localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW    = $clog2(Depth + 1);

    adal_pkg::t_cmd r_mem [Depth];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count != CW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/adal_engine.sv @@
// Back end: free queue, status store, fresh counter and response register.
`timescale 1ns / 1ps
`default_nettype none

module adal_engine #(
    parameter int MAX_DEVICES = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire adal_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    output logic                o_clearing,
    adal_rsp_if.source          o_rsp
);

    localparam int AW = $clog2(MAX_DEVICES);
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam int RW = AW + adal_pkg::ADDR_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              st_mem [MAX_DEVICES];
    logic [AW-1:0]     q_mem  [MAX_DEVICES];

    logic              r_state, n_state;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_idx;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_fresh, n_fresh;
    adal_pkg::t_cmd    r_cmd;
    logic              r_st_rd;
    logic [AW-1:0]     r_q_rd;
    logic              r_out_valid, n_out_valid;
    logic [adal_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [adal_pkg::STATUS_W-1:0] r_status, n_status;

    logic              pop;
    logic [RW-1:0]     pop_rel_ext;
    logic [AW-1:0]     pop_rel_idx;
    logic [RW-1:0]     rel_ext;
    logic              rel_in_range;
    logic [AW-1:0]     rel_idx;
    logic              cand_ok;
    logic [AW-1:0]     cand_addr;
    logic [RW-1:0]     cand_ext;
    logic              do_alloc;
    logic              do_release;
    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic              st_wdata;

    assign o_clearing      = r_clearing;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.granted_address = r_addr;
    assign o_rsp.status    = r_status;

    // Take a command only when the response register will be free for it.
    assign pop = (r_state == S_IDLE) && !r_clearing && i_cmd_valid
                 && (!r_out_valid || o_rsp.ready);
    assign o_cmd_ready = pop;

    // Status store read address of the command being taken.
    assign pop_rel_ext = {{AW{1'b0}}, i_cmd.rel};
    assign pop_rel_idx = pop_rel_ext[AW-1:0];

    assign rel_ext      = {{AW{1'b0}}, r_cmd.rel};
    assign rel_in_range = (rel_ext < RW'(MAX_DEVICES));
    assign rel_idx      = rel_ext[AW-1:0];

    // Reuse released addresses first, then the fresh counter.
    assign cand_ok   = (r_count != '0) || (r_fresh != CW'(MAX_DEVICES));
    assign cand_addr = (r_count != '0) ? r_q_rd : r_fresh[AW-1:0];
    assign cand_ext  = {{adal_pkg::ADDR_W{1'b0}}, cand_addr};

    always_comb begin
        do_alloc    = 1'b0;
        do_release  = 1'b0;
        n_addr      = r_addr;
        n_status    = r_status;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (pop) begin
            n_state = S_EXEC;
        end
        if (r_state == S_EXEC) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_addr      = '0;
            n_status    = adal_pkg::ST_OK;
            case (r_cmd.op)
                adal_pkg::OP_PEEK: begin
                    if (cand_ok) begin
                        n_addr = cand_ext[adal_pkg::ADDR_W-1:0];
                    end else begin
                        n_status = adal_pkg::ST_NO_FREE;
                    end
                end
                adal_pkg::OP_ALLOC: begin
                    if (!cand_ok) begin
                        n_status = adal_pkg::ST_NO_FREE;
                    end else if (!r_cmd.model_ok) begin
                        n_status = adal_pkg::ST_BAD_MODEL;
                    end else begin
                        do_alloc = 1'b1;
                        n_addr   = cand_ext[adal_pkg::ADDR_W-1:0];
                    end
                end
                adal_pkg::OP_RELEASE: begin
                    if (!rel_in_range || !r_st_rd || r_count == CW'(MAX_DEVICES)) begin
                        n_status = adal_pkg::ST_NOT_ACTIVE;
                    end else begin
                        do_release = 1'b1;
                    end
                end
                default: begin
                    n_status = adal_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_fresh = r_fresh;
        if (do_alloc) begin
            if (r_count != '0) begin
                n_head  = (r_head == AW'(MAX_DEVICES - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
            end else begin
                n_fresh = r_fresh + 1'b1;
            end
        end
        if (do_release) begin
            n_tail  = (r_tail == AW'(MAX_DEVICES - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    // One write port on the status store: sweep, allocate or release.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = cand_addr;
        st_wdata = 1'b0;
        if (r_clearing) begin
            st_we    = 1'b1;
            st_waddr = r_clr_idx;
        end else if (do_alloc) begin
            st_we    = 1'b1;
            st_wdata = 1'b1;
        end else if (do_release) begin
            st_we    = 1'b1;
            st_waddr = rel_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (pop) begin
            r_st_rd <= st_mem[pop_rel_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_release) begin
            q_mem[r_tail] <= rel_idx;
        end
        if (pop) begin
            r_q_rd <= q_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (r_clearing) begin
                if (r_clr_idx == AW'(MAX_DEVICES - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/device_address_allocator_unit.sv @@
// Top level of the device address allocator.
// Path: an accepted request passes the command queue, then the engine's command
// and read registers, then the response register that presents its response.
// The engine takes no new request while it executes the last one: it first
// reads the status store and the free queue through registers, then decides
// and writes back. Reset: synchronous, active low; afterwards the status store
// is swept clear, during which requests are held off (config is taken).
`timescale 1ns / 1ps
`default_nettype none

module device_address_allocator_unit #(
    parameter int MAX_DEVICES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adal_cfg_if.sink  i_cfg,
    adal_req_if.sink  i_req,
    adal_rsp_if.source o_rsp
);

    // Classified request word from the front end into the queue.
    adal_pkg::t_cmd front_cmd;
    logic           front_valid;
    logic           front_ready;

    // Queue head towards the engine.
    adal_pkg::t_cmd eng_cmd;
    logic           eng_valid;
    logic           eng_ready;

    // High while the engine sweeps the status store after reset.
    logic           clearing;

    // Front end: hold the model mask, check the model code at acceptance.
    adal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_req       (i_req),
        .i_clearing  (clearing),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    // Decouple acceptance from execution so each side stalls on its own.
    adal_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_cmd   (eng_cmd),
        .o_valid (eng_valid),
        .i_ready (eng_ready)
    );

    // Engine: pick the candidate address, update queue and status, respond.
    adal_engine #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (eng_cmd),
        .i_cmd_valid (eng_valid),
        .o_cmd_ready (eng_ready),
        .o_clearing  (clearing),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/adal_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adal_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [adal_pkg::ADDR_W-1:0]   i_rsp_addr,
    input wire logic [adal_pkg::STATUS_W-1:0] i_rsp_status
);

    // A refused request never reports an address.
    `ADAL_ASSERT_RST(a_refused_addr_zero, (i_rsp_valid && i_rsp_status != adal_pkg::ST_OK) |-> (i_rsp_addr == '0), "refused response carries an address")

    // A stalled response word holds.
    `ADAL_ASSERT_RST(a_rsp_hold, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_addr) && $stable(i_rsp_status)), "stalled response changed")

    // Reset drops the response and starts the sweep, so no request is taken.
    `ADAL_ASSERT(a_reset_quiet, !i_rst_n |=> (!i_rsp_valid && !i_req_ready), "activity right after reset")

endmodule

bind device_address_allocator_unit adal_checker u_adal_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_addr   (o_rsp.granted_address),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
